>>> sv/mi_pkg.sv
// mi_pkg: shared types, constants and microcode table of the modular inverse unit
// used by mi_seq, mi_dpath and modular_inverse_unit_core; no dependencies
package mi_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned PC_W           = 4;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_STEP,
    OP_INIT_B,
    OP_DIV_SETUP,
    OP_QRED,
    OP_MUL_STEP,
    OP_ROTATE,
    OP_FINISH
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_M_SMALL,
    CND_DIV_MORE,
    CND_B_ZERO,
    CND_MUL_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // status flags from datapath and channels to the sequencer
  typedef struct packed {
    logic in_valid;
    logic m_small;
    logic div_more;
    logic b_zero;
    logic mul_more;
    logic out_busy;
  } status_t;

  // step addresses
  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [PC_W-1:0] STEP_RED   = 4'd2;
  localparam logic [PC_W-1:0] STEP_INITB = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOOP  = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV   = 4'd5;
  localparam logic [PC_W-1:0] STEP_QRED  = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL   = 4'd7;
  localparam logic [PC_W-1:0] STEP_ROT   = 4'd8;
  localparam logic [PC_W-1:0] STEP_FIN   = 4'd9;
  localparam logic [PC_W-1:0] STEP_DONE  = 4'd10;

  // microcode program: jump to target when the condition holds, else next step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE:  w = '{op: OP_LOAD,      cond: CND_NO_START, target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_NOP,       cond: CND_M_SMALL,  target: STEP_FIN};
      STEP_RED:   w = '{op: OP_DIV_STEP,  cond: CND_DIV_MORE, target: STEP_RED};
      STEP_INITB: w = '{op: OP_INIT_B,    cond: CND_NEVER,    target: STEP_IDLE};
      STEP_LOOP:  w = '{op: OP_DIV_SETUP, cond: CND_B_ZERO,   target: STEP_FIN};
      STEP_DIV:   w = '{op: OP_DIV_STEP,  cond: CND_DIV_MORE, target: STEP_DIV};
      STEP_QRED:  w = '{op: OP_QRED,      cond: CND_NEVER,    target: STEP_IDLE};
      STEP_MUL:   w = '{op: OP_MUL_STEP,  cond: CND_MUL_MORE, target: STEP_MUL};
      STEP_ROT:   w = '{op: OP_ROTATE,    cond: CND_ALWAYS,   target: STEP_LOOP};
      STEP_FIN:   w = '{op: OP_FINISH,    cond: CND_OUT_BUSY, target: STEP_FIN};
      STEP_DONE:  w = '{op: OP_NOP,       cond: CND_ALWAYS,   target: STEP_IDLE};
      default:    w = '{op: OP_NOP,       cond: CND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/mi_seq.sv
// mi_seq: step counter, microcode table lookup and conditional jumps
// depends on mi_pkg
module mi_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mi_pkg::status_t status,
  output mi_pkg::uword_t  uword,
  output logic            in_stall
);

  logic [mi_pkg::PC_W-1:0] pc_r;
  logic [mi_pkg::PC_W-1:0] pc_nxt;
  logic                    take_jump;

  // fetch the control word of the current step
  assign uword    = mi_pkg::ucode_rom(pc_r);
  assign in_stall = (pc_r != mi_pkg::STEP_IDLE);

  // condition select
  always_comb begin
    unique case (uword.cond)
      mi_pkg::CND_NEVER:    take_jump = 1'b0;
      mi_pkg::CND_ALWAYS:   take_jump = 1'b1;
      mi_pkg::CND_NO_START: take_jump = !status.in_valid;
      mi_pkg::CND_M_SMALL:  take_jump = status.m_small;
      mi_pkg::CND_DIV_MORE: take_jump = status.div_more;
      mi_pkg::CND_B_ZERO:   take_jump = status.b_zero;
      mi_pkg::CND_MUL_MORE: take_jump = status.mul_more;
      mi_pkg::CND_OUT_BUSY: take_jump = status.out_busy;
      default:              take_jump = 1'b0;
    endcase
  end

  assign pc_nxt = take_jump ? uword.target : pc_r + 1'b1;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mi_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> sv/mi_dpath.sv
// mi_dpath: modulus register, bit-serial divider, shift-add modular multiplier,
// euclid coefficient registers and the result register; depends on mi_pkg
module mi_dpath #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mi_pkg::op_t           op,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  cfg_write,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_inverse,
  output logic                  out_no_inverse,
  output logic                  m_small,
  output logic                  div_more,
  output logic                  b_zero,
  output logic                  mul_more,
  output logic                  out_busy
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DATA_WIDTH);

  logic [W-1:0]  mod_r, a_r, b_r, tp_r, tc_r, q_r, rem_r, den_r, acc_r, x_r, y_r;
  logic [W-1:0]  inv_r;
  logic          nf_r, ov_r;
  logic [CW-1:0] cnt_r;

  logic [W:0]    shifted, trial, sum_ax, sum_xx, diff;
  logic [W-1:0]  rem_nxt, acc_nxt, x_nxt, xq_nxt, tc_nxt;
  logic          ge, fail;

  // divider: one quotient bit per cycle, restoring
  assign shifted = {rem_r, q_r[W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});
  assign rem_nxt = ge ? trial[W-1:0] : shifted[W-1:0];

  // modular add for the accumulator and the doubled multiplicand
  assign sum_ax  = {1'b0, acc_r} + {1'b0, x_r};
  assign acc_nxt = (sum_ax >= {1'b0, mod_r}) ? W'(sum_ax - {1'b0, mod_r}) : sum_ax[W-1:0];
  assign sum_xx  = {1'b0, x_r} + {1'b0, x_r};
  assign x_nxt   = (sum_xx >= {1'b0, mod_r}) ? W'(sum_xx - {1'b0, mod_r}) : sum_xx[W-1:0];

  // quotient reduced below the modulus (quotient never exceeds the modulus)
  assign xq_nxt  = (q_r >= mod_r) ? (q_r - mod_r) : q_r;

  // modular subtract for the next coefficient
  assign diff    = {1'b0, tp_r} - {1'b0, acc_r};
  assign tc_nxt  = diff[W] ? (diff[W-1:0] + mod_r) : diff[W-1:0];

  assign fail    = m_small || (a_r != W'(1));

  // status
  assign m_small  = (mod_r[W-1:1] == '0);
  assign div_more = (cnt_r != CW'(W - 1));
  assign b_zero   = (b_r == '0);
  assign mul_more = (y_r[W-1:1] != '0);
  assign out_busy = ov_r && out_stall;

  assign out_valid      = ov_r;
  assign out_inverse    = inv_r;
  assign out_no_inverse = nf_r;

  // control state: modulus, result valid, bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(2);
      ov_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_write) begin
        mod_r <= cfg_data;
      end
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      case (op)
        mi_pkg::OP_LOAD: begin
          if (start) begin
            cnt_r <= '0;
          end
        end
        mi_pkg::OP_DIV_SETUP: cnt_r <= '0;
        mi_pkg::OP_DIV_STEP:  cnt_r <= cnt_r + 1'b1;
        mi_pkg::OP_FINISH: begin
          if (!out_busy) begin
            ov_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (op)
      mi_pkg::OP_LOAD: begin
        if (start) begin
          q_r   <= in_value;
          rem_r <= '0;
          den_r <= mod_r;
          a_r   <= mod_r;
          tp_r  <= '0;
          tc_r  <= W'(1);
        end
      end
      mi_pkg::OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[W-2:0], ge};
      end
      mi_pkg::OP_INIT_B: b_r <= rem_r;
      mi_pkg::OP_DIV_SETUP: begin
        q_r   <= a_r;
        rem_r <= '0;
        den_r <= b_r;
      end
      mi_pkg::OP_QRED: begin
        x_r   <= xq_nxt;
        acc_r <= '0;
        y_r   <= tc_r;
      end
      mi_pkg::OP_MUL_STEP: begin
        if (y_r[0]) begin
          acc_r <= acc_nxt;
        end
        x_r <= x_nxt;
        y_r <= {1'b0, y_r[W-1:1]};
      end
      mi_pkg::OP_ROTATE: begin
        a_r  <= b_r;
        b_r  <= rem_r;
        tp_r <= tc_r;
        tc_r <= tc_nxt;
      end
      mi_pkg::OP_FINISH: begin
        if (!out_busy) begin
          inv_r <= fail ? '0 : tp_r;
          nf_r  <= fail;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/modular_inverse_unit_core.sv
// Modular inverse unit: returns value^-1 mod modulus by the extended Euclidean
// recurrence, run by a microcoded sequencer over a bit-serial datapath. One item
// is in work at a time. The next item is accepted after the result is issued
// and the program has passed the done step back to idle. W is DATA_WIDTH; the
// Euclid recurrence takes up to about 46 steps at 32 bits. The divider, one
// quotient bit per cycle, and the shift-add modular multiplier, one multiplier
// bit per cycle, do the work of each step; the multiplier runs over the k bits
// of the coefficient multiplied in that step (k is 1 to W). A modulus below two
// skips the work and goes from the check step straight to the finish step. The
// result register frees the input while a finished result waits. Write the
// modulus only while the unit is idle. A value with no inverse (zero mod modulus
// or gcd not one) gives no_inverse 1 and inverse 0; the result is otherwise in
// the range 0 to modulus-1.
module modular_inverse_unit_core #(
  parameter int unsigned DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_inverse,
  output logic                  out_no_inverse,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DATA_WIDTH-1:0] cfg_modulus
);

  mi_pkg::uword_t  uword;
  mi_pkg::status_t status;
  logic            in_fire;
  logic            m_small, div_more, b_zero, mul_more, out_busy;

  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // collect status for the sequencer
  assign status = '{in_valid: in_valid, m_small: m_small, div_more: div_more,
                    b_zero: b_zero, mul_more: mul_more, out_busy: out_busy};

  mi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .uword    (uword),
    .in_stall (in_stall)
  );

  mi_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (uword.op),
    .start          (in_fire),
    .in_value       (in_value),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_modulus),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse),
    .m_small        (m_small),
    .div_more       (div_more),
    .b_zero         (b_zero),
    .mul_more       (mul_more),
    .out_busy       (out_busy)
  );

  // an accepted item keeps the input closed until the program returns
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after item accept");

  // a failed result always carries zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_inverse |-> out_inverse == '0)
    else $error("no_inverse result with nonzero inverse");

  // a new result appears only from the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(uword.op == mi_pkg::OP_FINISH))
    else $error("result valid raised outside finish step");

endmodule

>>> tb/sv/tb_modular_inverse_unit_core.sv
// tb_modular_inverse_unit_core: self-checking bench for the modular inverse unit
// drives value items against a predicted inverse and flag under several moduli
// depends on mi_pkg and modular_inverse_unit_core
module tb_modular_inverse_unit_core;

  localparam int unsigned W           = mi_pkg::DATA_WIDTH_DEF;
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam int unsigned MAX_CYCLES  = 5_000_000;

  typedef struct {
    bit [W-1:0] inverse;
    bit         no_inv;
  } inv_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_value = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_inverse;
  logic         out_no_inverse;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [W-1:0] cfg_modulus = '0;

  bit [W-1:0] pending_values[$];
  inv_t       due_inverses[$];
  bit [W-1:0] cur_modulus = 2;
  int         n_pushed = 0;
  int         n_taken = 0;
  int         bad_results = 0;
  int         cycle_count = 0;
  int         snd_idle = 0;
  int         rcv_idle = 0;
  logic       sent_ok = 1'b0;
  logic       hold_on = 1'b0;
  event       start_hold;

  modular_inverse_unit_core #(.DATA_WIDTH(W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_modulus    (cfg_modulus)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // extended euclid with coefficients kept reduced mod m
  function automatic inv_t mod_inverse(input bit [W-1:0] val, input bit [W-1:0] m);
    longint unsigned r_old, r_new, r_nxt, t_old, t_new, t_nxt, q, prod;
    inv_t res;
    res = '{inverse: '0, no_inv: 1'b1};
    if (m >= 2) begin
      r_old = m;
      r_new = val % m;
      t_old = 0;
      t_new = 1;
      while (r_new != 0) begin
        q     = r_old / r_new;
        r_nxt = r_old - q * r_new;
        prod  = ((q % m) * t_new) % m;
        t_nxt = (t_old >= prod) ? (t_old - prod) : (t_old + (m - prod));
        r_old = r_new;
        r_new = r_nxt;
        t_old = t_new;
        t_new = t_nxt;
      end
      if (r_old == 1) res = '{inverse: t_old[W-1:0], no_inv: 1'b0};
    end
    return res;
  endfunction

  // sender: next item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sent_ok) begin
      if (pending_values.size() != 0 && $urandom_range(99) >= snd_idle) begin
        in_valid <= 1'b1;
        in_value <= pending_values.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted items produce expectations
  always @(posedge clk) begin
    sent_ok <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      due_inverses.push_back(mod_inverse(in_value, cur_modulus));
      n_taken++;
    end
  end

  // receiver stall, random plus long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_on || ($urandom_range(99) < rcv_idle);
  end

  // long hold-off counted in its own process
  always begin
    @(start_hold);
    for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk) hold_on <= 1'b1;
    @(posedge clk) hold_on <= 1'b0;
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    inv_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (due_inverses.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: inverse %h flag %b", out_inverse, out_no_inverse);
      end else begin
        exp_res = due_inverses.pop_front();
        if (out_inverse !== exp_res.inverse || out_no_inverse !== exp_res.no_inv) begin
          bad_results++;
          if (bad_results <= 10)
            $display("bad result: expected inverse %h flag %b, got inverse %h flag %b",
                     exp_res.inverse, exp_res.no_inv, out_inverse, out_no_inverse);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("modular_inverse_unit_core: mismatch");
      $finish;
    end
  end

  task automatic offer(input bit [W-1:0] v);
    pending_values.push_back(v);
    n_pushed++;
  endtask

  task automatic drain();
    while (n_taken != n_pushed || due_inverses.size() != 0) @(posedge clk);
  endtask

  // register write while the unit is idle
  task automatic set_modulus(input bit [W-1:0] m);
    @(negedge clk);
    cfg_valid   = 1'b1;
    cfg_modulus = m;
    do @(posedge clk); while (!cfg_ready);
    cur_modulus = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random values shaped around the current modulus
  task automatic random_items(input int count);
    longint unsigned m, v;
    for (int i = 0; i < count; i++) begin
      m = cur_modulus;
      case ($urandom_range(5))
        0: v = $urandom;
        1: v = $urandom_range(16);
        2: v = m - $urandom_range(3);
        3: v = m * $urandom_range(1, 3) + $urandom_range(2);
        4: v = $urandom % m;
        default: v = longint'($urandom_range(2, 7)) * $urandom_range(1, 1000);
      endcase
      offer(v[W-1:0]);
    end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // sender idles often, receiver more
    snd_idle = 28;
    rcv_idle = 78;

    // modulus from reset
    offer(0); offer(1); offer(2); offer(3); offer('1);
    random_items(40);
    drain();

    // all-ones modulus, composite; long receiver hold-off
    set_modulus('1);
    offer(0); offer(1); offer(32'hFFFF_FFFE); offer('1); offer(3); offer(32'h8000_0000);
    -> start_hold;
    random_items(40);
    drain();

    // largest 32-bit prime
    set_modulus(32'hFFFF_FFFB);
    offer(32'hFFFF_FFFA); offer(32'hFFFF_FFFC); offer(32'h7FFF_FFFF);
    random_items(40);
    drain();

    // roles swapped
    snd_idle = 78;
    rcv_idle = 28;

    set_modulus(2);
    random_items(40);
    drain();

    set_modulus(97);
    offer(96); offer(194); offer(1);
    random_items(40);
    drain();

    set_modulus(3120);
    offer(7); offer(1560);
    random_items(40);
    drain();

    // no idling
    snd_idle = 0;
    rcv_idle = 0;

    // consecutive fibonacci numbers give the longest euclid chain
    set_modulus(32'd2971215073);
    offer(32'd1836311903); offer(1);
    random_items(40);
    drain();

    set_modulus($urandom | 32'h8000_0000);
    random_items(40);
    drain();

    set_modulus($urandom_range(2, 65535));
    random_items(40);
    drain();

    set_modulus($urandom_range(2, 50));
    random_items(40);
    drain();

    repeat (20) @(posedge clk);
    if (bad_results == 0 && due_inverses.size() == 0) begin
      $display("modular_inverse_unit_core: match");
    end else begin
      $display("modular_inverse_unit_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mi_pkg.sv
sv/mi_seq.sv
sv/mi_dpath.sv
sv/modular_inverse_unit_core.sv
tb/sv/tb_modular_inverse_unit_core.sv
